// ===== rtl/flm_pkg.sv =====
package flm_pkg;

	// sizes fixed by the item layout
	localparam int FLM_MAX_FAULTS  = 10;
	localparam int FLM_LOW_FAULTS  = 5;
	localparam int FLM_TIME_W      = 12;
	localparam int FLM_NOW_W       = 32;
	localparam int FLM_CFG_W       = 60;
	localparam int FLM_CFG_IDX_W   = 3;
	localparam int FLM_IN_TDATA_W  = 72;
	localparam int FLM_OUT_TDATA_W = 72;

	// item kinds carried in tuser
	localparam logic FUNC_EVALUATE     = 1'b0;
	localparam logic FUNC_MANUAL_CLEAR = 1'b1;

	// register reset values
	localparam logic [FLM_CFG_W-1:0] CONFIRM_LO_RST  = 60'd140771856484352500;
	localparam logic [FLM_CFG_W-1:0] CONFIRM_HI_RST  = 60'd34359738368100;
	localparam logic [FLM_CFG_W-1:0] RECOVERY_LO_RST = 60'd281543712968705000;
	localparam logic [FLM_CFG_W-1:0] RECOVERY_HI_RST = 60'd281543712968705000;
	localparam logic [FLM_MAX_FAULTS-1:0] CRITICAL_RST = 10'd767;
	localparam logic [FLM_MAX_FAULTS-1:0] MANUAL_RST   = 10'd767;
	localparam logic [FLM_MAX_FAULTS-1:0] INJECT_RST   = 10'd0;

	typedef enum logic [1:0] {
		PH_CLEAR     = 2'd0,
		PH_PENDING   = 2'd1,
		PH_CONFIRMED = 2'd2,
		PH_RECOVERY  = 2'd3
	} flm_phase_t;

	typedef enum logic [FLM_CFG_IDX_W-1:0] {
		REG_CONFIRM_LO  = 3'd0,
		REG_CONFIRM_HI  = 3'd1,
		REG_RECOVERY_LO = 3'd2,
		REG_RECOVERY_HI = 3'd3,
		REG_CRITICAL    = 3'd4,
		REG_MANUAL      = 3'd5,
		REG_INJECT      = 3'd6
	} flm_reg_t;

	typedef logic [FLM_MAX_FAULTS-1:0] flm_mask_t;
	typedef logic [FLM_MAX_FAULTS-1:0][FLM_TIME_W-1:0] flm_time_arr_t;

	// strobes and condition bits into one fault lane
	typedef struct packed {
		logic eval;
		logic mclear;
		logic trip;
		logic rec;
	} flm_lane_ctl_t;

	// current and next view of one fault lane
	typedef struct packed {
		flm_phase_t phase_cur;
		logic       ready_cur;
		flm_phase_t phase_nxt;
		logic       ready_nxt;
		logic       confirm_evt;
		logic       clear_evt;
	} flm_lane_stat_t;

endpackage

// ===== rtl/flm_cfg_regs.sv =====
module flm_cfg_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   wr_en,
	input  logic [flm_pkg::FLM_CFG_IDX_W-1:0]      wr_index,
	input  logic [flm_pkg::FLM_CFG_W-1:0]          wr_data,
	output flm_pkg::flm_time_arr_t                 confirm_time,
	output flm_pkg::flm_time_arr_t                 recovery_time,
	output flm_pkg::flm_mask_t                     critical,
	output flm_pkg::flm_mask_t                     manual,
	output flm_pkg::flm_mask_t                     inject
);
	import flm_pkg::*;

	logic [FLM_CFG_W-1:0] confirm_lo_q, confirm_hi_q, recovery_lo_q, recovery_hi_q;
	flm_mask_t            critical_q, manual_q, inject_q;

	// write one register per beat, ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_lo_q  <= CONFIRM_LO_RST;
			confirm_hi_q  <= CONFIRM_HI_RST;
			recovery_lo_q <= RECOVERY_LO_RST;
			recovery_hi_q <= RECOVERY_HI_RST;
			critical_q    <= CRITICAL_RST;
			manual_q      <= MANUAL_RST;
			inject_q      <= INJECT_RST;
		end else if (wr_en) begin
			case (flm_reg_t'(wr_index))
				REG_CONFIRM_LO:  confirm_lo_q  <= wr_data;
				REG_CONFIRM_HI:  confirm_hi_q  <= wr_data;
				REG_RECOVERY_LO: recovery_lo_q <= wr_data;
				REG_RECOVERY_HI: recovery_hi_q <= wr_data;
				REG_CRITICAL:    critical_q    <= wr_data[FLM_MAX_FAULTS-1:0];
				REG_MANUAL:      manual_q      <= wr_data[FLM_MAX_FAULTS-1:0];
				REG_INJECT:      inject_q      <= wr_data[FLM_MAX_FAULTS-1:0];
				default: ;
			endcase
		end
	end

	// unpack the 12-bit time fields, fault 0 in the lowest bits
	for (genvar g = 0; g < FLM_MAX_FAULTS; g++) begin : g_unpack
		if (g < FLM_LOW_FAULTS) begin : g_lo
			assign confirm_time[g]  = confirm_lo_q[g*FLM_TIME_W +: FLM_TIME_W];
			assign recovery_time[g] = recovery_lo_q[g*FLM_TIME_W +: FLM_TIME_W];
		end else begin : g_hi
			assign confirm_time[g]  =
				confirm_hi_q[(g-FLM_LOW_FAULTS)*FLM_TIME_W +: FLM_TIME_W];
			assign recovery_time[g] =
				recovery_hi_q[(g-FLM_LOW_FAULTS)*FLM_TIME_W +: FLM_TIME_W];
		end
	end

	assign critical = critical_q;
	assign manual   = manual_q;
	assign inject   = inject_q;

endmodule

// ===== rtl/flm_fault_lane.sv =====
module flm_fault_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  flm_pkg::flm_lane_ctl_t            ctl,
	input  logic [flm_pkg::FLM_NOW_W-1:0]     now_ms,
	input  logic [flm_pkg::FLM_TIME_W-1:0]    confirm_time,
	input  logic [flm_pkg::FLM_TIME_W-1:0]    recovery_time,
	input  logic                              latching,
	output flm_pkg::flm_lane_stat_t           stat
);
	import flm_pkg::*;

	flm_phase_t           phase_q, phase_d;
	logic [FLM_NOW_W-1:0] start_q, start_d;
	logic                 ready_q, ready_d;
	logic [FLM_NOW_W-1:0] elapsed;
	logic                 confirm_met, recovery_met;
	logic                 confirm_evt, clear_evt;

	// hold times measured modulo 2^32
	assign elapsed      = now_ms - start_q;
	assign confirm_met  = elapsed >= FLM_NOW_W'(confirm_time);
	assign recovery_met = elapsed >= FLM_NOW_W'(recovery_time);

	// phase transitions for one evaluate update or one manual clear
	always_comb begin
		phase_d     = phase_q;
		start_d     = start_q;
		ready_d     = ready_q;
		confirm_evt = 1'b0;
		clear_evt   = 1'b0;
		if (ctl.mclear) begin
			phase_d = PH_CLEAR;
			start_d = '0;
			ready_d = 1'b0;
		end else if (ctl.eval) begin
			case (phase_q)
				PH_CLEAR: begin
					ready_d = 1'b0;
					if (ctl.trip) begin
						start_d = now_ms;
						if (confirm_time == '0) begin
							phase_d     = PH_CONFIRMED;
							confirm_evt = 1'b1;
						end else begin
							phase_d = PH_PENDING;
						end
					end
				end
				PH_PENDING: begin
					if (!ctl.trip) begin
						phase_d = PH_CLEAR;
						start_d = '0;
						ready_d = 1'b0;
					end else if (confirm_met) begin
						phase_d     = PH_CONFIRMED;
						start_d     = now_ms;
						ready_d     = 1'b0;
						confirm_evt = 1'b1;
					end
				end
				PH_CONFIRMED: begin
					ready_d = 1'b0;
					if (ctl.rec) begin
						phase_d = PH_RECOVERY;
						start_d = now_ms;
						ready_d = (recovery_time == '0);
					end
				end
				PH_RECOVERY: begin
					if (ctl.trip || !ctl.rec) begin
						phase_d = PH_CONFIRMED;
						start_d = now_ms;
						ready_d = 1'b0;
					end else if (recovery_met) begin
						ready_d = 1'b1;
						if (!latching) begin
							phase_d   = PH_CLEAR;
							start_d   = '0;
							ready_d   = 1'b0;
							clear_evt = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// hold lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CLEAR;
			start_q <= '0;
			ready_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			start_q <= start_d;
			ready_q <= ready_d;
		end
	end

	assign stat.phase_cur   = phase_q;
	assign stat.ready_cur   = ready_q;
	assign stat.phase_nxt   = phase_d;
	assign stat.ready_nxt   = ready_d;
	assign stat.confirm_evt = confirm_evt;
	assign stat.clear_evt   = clear_evt;

endmodule

// ===== rtl/fault_lifecycle_manager.sv =====
// An input beat passes the input register and then the result register before it is output.
// Throughput: one item per cycle while the result side is not stalled; the fault lanes update
// in parallel as an item leaves the input register; a stalled output blocks the input side.
// Reset: arst_n clears every fault to CLEAR with no timing or ready state, clears the event
// masks and loads the register defaults; items in the input and result registers are dropped.
module fault_lifecycle_manager #(
	parameter int FAULT_COUNT = flm_pkg::FLM_MAX_FAULTS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// trip_vector, recovery_vector, update_select, now_ms, clear_request
	input  logic [flm_pkg::FLM_IN_TDATA_W-1:0]    s_tdata,
	// func
	input  logic                                  s_tuser,
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// active, latched, critical, recovery ready, new confirms, new clears,
	// cleared now, zero pad
	output logic [flm_pkg::FLM_OUT_TDATA_W-1:0]   m_tdata,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [flm_pkg::FLM_CFG_IDX_W-1:0]     cfg_index,
	input  logic [flm_pkg::FLM_CFG_W-1:0]         cfg_data
);
	import flm_pkg::*;

	localparam int MW = FLM_MAX_FAULTS;

	// input register
	logic                 valid_s1;
	logic                 func_s1;
	flm_mask_t            trip_s1, rec_s1, sel_s1, req_s1;
	logic [FLM_NOW_W-1:0] now_s1;

	// result register
	logic      out_valid_q;
	flm_mask_t active_q, latched_q, critical_q, ready_q, new_conf_q, new_clr_q, clr_now_q;

	// event masks
	flm_mask_t conf_evt_q, clr_evt_q, conf_evt_d, clr_evt_d;

	// configuration
	flm_time_arr_t confirm_time, recovery_time;
	flm_mask_t     critical, manual, inject;

	// lane views
	flm_mask_t active_cur, ready_cur, active_nxt, ready_nxt, confirm_bits, clear_bits;
	flm_mask_t clr_now;
	logic      advance;
	logic      eval_round;

	assign advance    = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready   = !valid_s1 || advance;
	assign eval_round = (func_s1 == FUNC_EVALUATE);
	assign cfg_ready  = 1'b1;

	flm_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (cfg_valid && cfg_ready),
		.wr_index      (cfg_index),
		.wr_data       (cfg_data),
		.confirm_time  (confirm_time),
		.recovery_time (recovery_time),
		.critical      (critical),
		.manual        (manual),
		.inject        (inject)
	);

	// capture an input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser;
			trip_s1 <= s_tdata[9:0];
			rec_s1  <= s_tdata[19:10];
			sel_s1  <= s_tdata[29:20];
			now_s1  <= s_tdata[61:30];
			req_s1  <= s_tdata[71:62];
		end
	end

	// one lane per fault; lanes past FAULT_COUNT read as cleared
	for (genvar g = 0; g < MW; g++) begin : g_lane
		if (g < FAULT_COUNT) begin : g_used
			flm_lane_ctl_t  lane_ctl;
			flm_lane_stat_t lane_stat;

			assign active_cur[g] = (lane_stat.phase_cur == PH_CONFIRMED) ||
				(lane_stat.phase_cur == PH_RECOVERY);
			assign ready_cur[g]  = lane_stat.ready_cur;
			assign active_nxt[g] = (lane_stat.phase_nxt == PH_CONFIRMED) ||
				(lane_stat.phase_nxt == PH_RECOVERY);
			assign ready_nxt[g]    = lane_stat.ready_nxt;
			assign confirm_bits[g] = lane_stat.confirm_evt;
			assign clear_bits[g]   = lane_stat.clear_evt;
			assign clr_now[g]      = !eval_round && req_s1[g] && active_cur[g] &&
				manual[g] && ready_cur[g];

			// injection forces trip on and recovery off
			assign lane_ctl.eval   = advance && eval_round && sel_s1[g];
			assign lane_ctl.mclear = advance && clr_now[g];
			assign lane_ctl.trip   = trip_s1[g] || inject[g];
			assign lane_ctl.rec    = rec_s1[g] && !inject[g];

			flm_fault_lane u_lane (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctl           (lane_ctl),
				.now_ms        (now_s1),
				.confirm_time  (confirm_time[g]),
				.recovery_time (recovery_time[g]),
				.latching      (manual[g]),
				.stat          (lane_stat)
			);
		end else begin : g_unused
			assign active_cur[g]   = 1'b0;
			assign ready_cur[g]    = 1'b0;
			assign active_nxt[g]   = 1'b0;
			assign ready_nxt[g]    = 1'b0;
			assign confirm_bits[g] = 1'b0;
			assign clear_bits[g]   = 1'b0;
			assign clr_now[g]      = 1'b0;
		end
	end

	// restart event masks on evaluate, accumulate manual clears
	assign conf_evt_d = eval_round ? confirm_bits : conf_evt_q;
	assign clr_evt_d  = eval_round ? clear_bits : (clr_evt_q | clr_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_evt_q <= '0;
			clr_evt_q  <= '0;
		end else if (advance) begin
			conf_evt_q <= conf_evt_d;
			clr_evt_q  <= clr_evt_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// load result masks from the updated state
	always_ff @(posedge clk) begin
		if (advance) begin
			active_q   <= active_nxt;
			latched_q  <= active_nxt & manual;
			critical_q <= active_nxt & critical;
			ready_q    <= active_nxt & ready_nxt;
			new_conf_q <= conf_evt_d;
			new_clr_q  <= clr_evt_d;
			clr_now_q  <= clr_now;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, clr_now_q, new_clr_q, new_conf_q, ready_q, critical_q,
		latched_q, active_q};

`ifndef ASSERT_OFF
	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("result register not loaded after advance");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input taken while both registers are full");

	a_cleared_not_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((clr_now_q & active_q) == '0) && ((new_clr_q & active_q) == '0))
		else $error("cleared fault still reported active");

	a_events_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((new_conf_q & new_clr_q) == '0))
		else $error("fault both confirmed and cleared in one round");
`endif

endmodule

// ===== verif/fault_lifecycle_checker.sv =====
`timescale 1ns / 100ps

module fault_lifecycle_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [flm_pkg::FLM_IN_TDATA_W-1:0]  s_tdata,
	input  logic                                s_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [flm_pkg::FLM_OUT_TDATA_W-1:0] m_tdata,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [flm_pkg::FLM_CFG_IDX_W-1:0]   cfg_index,
	input  logic [flm_pkg::FLM_CFG_W-1:0]       cfg_data,
	output int                                  fail_count,
	output int                                  expect_depth,
	output int                                  eval_beats,
	output int                                  clear_beats,
	output int                                  confirm_total,
	output int                                  release_total
);
	import flm_pkg::*;

	localparam int NF       = FLM_MAX_FAULTS;
	localparam int STATUS_W = 7 * NF;

	// shadow copy of the register file
	logic [FLM_CFG_W-1:0] confirm_lo, confirm_hi, recovery_lo, recovery_hi;
	flm_mask_t            critical_set, latching_set, inject_set;

	// shadow copy of the fault lanes
	flm_phase_t           phase [NF];
	logic [FLM_NOW_W-1:0] phase_since [NF];
	flm_mask_t            ready_set, confirmed_evts, cleared_evts;

	// status words still owed by the block, oldest first, packed as on m_tdata
	logic [STATUS_W-1:0]  expected_status [$];

	function automatic logic [FLM_TIME_W-1:0] lane_time(input logic [FLM_CFG_W-1:0] lo,
			input logic [FLM_CFG_W-1:0] hi, input int i);
		if (i < FLM_LOW_FAULTS)
			return lo[i*FLM_TIME_W +: FLM_TIME_W];
		return hi[(i-FLM_LOW_FAULTS)*FLM_TIME_W +: FLM_TIME_W];
	endfunction

	function automatic flm_mask_t active_lanes();
		flm_mask_t m;
		m = '0;
		for (int i = 0; i < NF; i++)
			m[i] = (phase[i] == PH_CONFIRMED) || (phase[i] == PH_RECOVERY);
		return m;
	endfunction

	function automatic string field_name(input int f);
		case (f)
		0: return "active_faults";
		1: return "latched_faults";
		2: return "critical_active";
		3: return "ready_faults";
		4: return "confirm_events";
		5: return "clear_events";
		default: return "cleared_now";
		endcase
	endfunction

	task automatic clear_lane(input int i);
		phase[i]       = PH_CLEAR;
		phase_since[i] = '0;
		ready_set[i]   = 1'b0;
	endtask

	task automatic confirm_lane(input int i, input logic [FLM_NOW_W-1:0] now_ms);
		phase[i]          = PH_CONFIRMED;
		phase_since[i]    = now_ms;
		ready_set[i]      = 1'b0;
		confirmed_evts[i] = 1'b1;
		confirm_total++;
	endtask

	// one evaluate step of a single fault lane
	task automatic step_lane(input int i, input logic trip, input logic rec,
			input logic [FLM_NOW_W-1:0] now_ms);
		logic [FLM_TIME_W-1:0] ctime, rtime;
		logic [FLM_NOW_W-1:0]  elapsed;
		ctime   = lane_time(confirm_lo, confirm_hi, i);
		rtime   = lane_time(recovery_lo, recovery_hi, i);
		elapsed = now_ms - phase_since[i];
		// injection overrides the condition bits
		if (inject_set[i]) begin
			trip = 1'b1;
			rec  = 1'b0;
		end
		case (phase[i])
		PH_CLEAR: begin
			ready_set[i] = 1'b0;
			if (trip) begin
				if (ctime == '0) begin
					confirm_lane(i, now_ms);
				end else begin
					phase[i]       = PH_PENDING;
					phase_since[i] = now_ms;
				end
			end
		end
		PH_PENDING: begin
			if (!trip)
				clear_lane(i);
			else if (elapsed >= FLM_NOW_W'(ctime))
				confirm_lane(i, now_ms);
		end
		PH_CONFIRMED: begin
			ready_set[i] = 1'b0;
			if (rec) begin
				phase[i]       = PH_RECOVERY;
				phase_since[i] = now_ms;
				if (rtime == '0)
					ready_set[i] = 1'b1;
			end
		end
		default: begin
			if (trip || !rec) begin
				phase[i]       = PH_CONFIRMED;
				phase_since[i] = now_ms;
				ready_set[i]   = 1'b0;
			end else if (elapsed >= FLM_NOW_W'(rtime)) begin
				ready_set[i] = 1'b1;
				// non-latching faults release themselves
				if (!latching_set[i]) begin
					cleared_evts[i] = 1'b1;
					release_total++;
					clear_lane(i);
				end
			end
		end
		endcase
	endtask

	// apply one input beat and work out the status word it produces
	task automatic advance_faults(input logic kind, input logic [FLM_IN_TDATA_W-1:0] data,
			output logic [STATUS_W-1:0] status);
		flm_mask_t            trip, rec, sel, req, active, freed;
		logic [FLM_NOW_W-1:0] now_ms;
		trip   = data[0 +: NF];
		rec    = data[NF +: NF];
		sel    = data[2*NF +: NF];
		now_ms = data[3*NF +: FLM_NOW_W];
		req    = data[3*NF+FLM_NOW_W +: NF];
		freed  = '0;
		if (kind == FUNC_EVALUATE) begin
			confirmed_evts = '0;
			cleared_evts   = '0;
			for (int i = 0; i < NF; i++)
				if (sel[i])
					step_lane(i, trip[i], rec[i], now_ms);
			eval_beats++;
		end else begin
			freed = req & active_lanes() & latching_set & ready_set;
			for (int i = 0; i < NF; i++)
				if (freed[i]) begin
					cleared_evts[i] = 1'b1;
					release_total++;
					clear_lane(i);
				end
			clear_beats++;
		end
		active = active_lanes();
		status = {freed, cleared_evts, confirmed_evts, active & ready_set,
			active & critical_set, active & latching_set, active};
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		logic [STATUS_W-1:0] want, got;
		if (!arst_n) begin
			confirm_lo     = CONFIRM_LO_RST;
			confirm_hi     = CONFIRM_HI_RST;
			recovery_lo    = RECOVERY_LO_RST;
			recovery_hi    = RECOVERY_HI_RST;
			critical_set   = CRITICAL_RST;
			latching_set   = MANUAL_RST;
			inject_set     = INJECT_RST;
			for (int i = 0; i < NF; i++)
				clear_lane(i);
			confirmed_evts = '0;
			cleared_evts   = '0;
			expected_status.delete();
			fail_count     = 0;
			eval_beats     = 0;
			clear_beats    = 0;
			confirm_total  = 0;
			release_total  = 0;
			expect_depth  <= 0;
		end else begin
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (flm_reg_t'(cfg_index))
				REG_CONFIRM_LO:  confirm_lo   = cfg_data;
				REG_CONFIRM_HI:  confirm_hi   = cfg_data;
				REG_RECOVERY_LO: recovery_lo  = cfg_data;
				REG_RECOVERY_HI: recovery_hi  = cfg_data;
				REG_CRITICAL:    critical_set = cfg_data[NF-1:0];
				REG_MANUAL:      latching_set = cfg_data[NF-1:0];
				REG_INJECT:      inject_set   = cfg_data[NF-1:0];
				default: ;
				endcase
			end
			// compare each result beat with the oldest owed status
			if (m_tvalid && m_tready) begin
				got = m_tdata[STATUS_W-1:0];
				if (expected_status.size() == 0) begin
					$error("result beat %h arrived with no item outstanding", got);
					fail_count++;
				end else begin
					want = expected_status.pop_front();
					for (int f = 0; f < 7; f++)
						if (got[f*NF +: NF] !== want[f*NF +: NF]) begin
							$error("%s: expected %h, actual %h", field_name(f),
								want[f*NF +: NF], got[f*NF +: NF]);
							fail_count++;
						end
				end
			end
			// predict every accepted input beat
			if (s_tvalid && s_tready) begin
				advance_faults(s_tuser, s_tdata, want);
				expected_status.push_back(want);
			end
			expect_depth <= expected_status.size();
		end
	end

endmodule

// ===== verif/fault_lifecycle_manager_tb.sv =====
`timescale 1ns / 100ps

module fault_lifecycle_manager_tb;
	import flm_pkg::*;

	localparam int PHASE_ITEMS = 105;
	localparam int HOLD_CYCLES = 80;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [FLM_CFG_W-1:0] TIMES_MAX = '1;

	typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} ready_style_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       s_tvalid  = 1'b0;
	logic                       s_tready;
	logic [FLM_IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                       s_tuser   = FUNC_EVALUATE;
	logic                       m_tvalid;
	logic                       m_tready  = 1'b0;
	logic [FLM_OUT_TDATA_W-1:0] m_tdata;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [FLM_CFG_IDX_W-1:0]   cfg_index = REG_CONFIRM_LO;
	logic [FLM_CFG_W-1:0]       cfg_data  = '0;

	int fail_count, expect_depth, eval_beats, clear_beats, confirm_total, release_total;
	int cycle_count = 0;
	int hold_asks   = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int mode_left   = 0;
	int burst_left  = 0;
	ready_style_t ready_style = READY_ALWAYS;

	fault_lifecycle_manager i_dut (.*);

	fault_lifecycle_checker i_check (.*);

	always #10 clk = ~clk;

	// guard against a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[fault_lifecycle_manager] ERROR");
			$finish;
		end
	end

	// result side: change stall style now and then, serve long hold requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready    <= 1'b0;
			hold_left   <= 0;
			hold_served <= 0;
			mode_left   <= 0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asks) begin
			m_tready    <= 1'b0;
			hold_left   <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else begin
			if (mode_left == 0) begin
				ready_style <= ready_style_t'($urandom_range(0, 3));
				mode_left   <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_style)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN:   m_tready <= ($urandom_range(0, 1) == 0);
			READY_SPARSE: m_tready <= (mode_left % 4 == 0);
			default:      m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	function automatic flm_mask_t rand_mask();
		return flm_mask_t'($urandom_range(0, 1023));
	endfunction

	// five 12-bit hold times, each up to limit_ms
	function automatic logic [FLM_CFG_W-1:0] rand_times(input int limit_ms);
		logic [FLM_CFG_W-1:0] v;
		for (int f = 0; f < FLM_LOW_FAULTS; f++)
			v[f*FLM_TIME_W +: FLM_TIME_W] = FLM_TIME_W'($urandom_range(0, limit_ms));
		return v;
	endfunction

	function automatic logic [FLM_CFG_W-1:0] rand_word();
		return {28'($urandom()), $urandom()};
	endfunction

	function automatic logic [FLM_IN_TDATA_W-1:0] pack_item(input flm_mask_t trip,
			input flm_mask_t rec, input flm_mask_t sel, input logic [FLM_NOW_W-1:0] now_ms,
			input flm_mask_t req);
		return {req, now_ms, sel, rec, trip};
	endfunction

	// offer one beat, with random gaps between bursts
	task automatic send_item(input logic kind, input logic [FLM_IN_TDATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// drop valid and wait for every owed result
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expect_depth != 0);
	endtask

	task automatic put_reg(input flm_reg_t idx, input logic [FLM_CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [FLM_CFG_W-1:0] c_lo, input logic [FLM_CFG_W-1:0] c_hi,
			input logic [FLM_CFG_W-1:0] r_lo, input logic [FLM_CFG_W-1:0] r_hi,
			input flm_mask_t crit, input flm_mask_t latch, input flm_mask_t inj);
		put_reg(REG_CONFIRM_LO, c_lo);
		put_reg(REG_CONFIRM_HI, c_hi);
		put_reg(REG_RECOVERY_LO, r_lo);
		put_reg(REG_RECOVERY_HI, r_hi);
		put_reg(REG_CRITICAL, FLM_CFG_W'(crit));
		put_reg(REG_MANUAL, FLM_CFG_W'(latch));
		put_reg(REG_INJECT, FLM_CFG_W'(inj));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                   roll, step_max;
		logic [FLM_NOW_W-1:0] tick_ms;
		flm_mask_t            trip_cond, rec_cond, sel;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// immediate confirm and zero recovery, half the faults latching
		configure('0, '0, '0, '0, 10'h2AA, 10'h155, '0);
		send_item(FUNC_EVALUATE, pack_item(10'h3FF, 10'h000, 10'h3FF, 32'd0, 10'h000));
		// trip and recovery together while confirmed
		send_item(FUNC_EVALUATE, pack_item(10'h3FF, 10'h3FF, 10'h3FF, 32'd1, 10'h000));
		send_item(FUNC_MANUAL_CLEAR, pack_item(10'h000, 10'h000, 10'h000, 32'd1, 10'h3FF));
		// held trip bit sends recovery back to confirmed
		send_item(FUNC_EVALUATE, pack_item(10'h3FF, 10'h3FF, 10'h3FF, 32'd2, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h3FF, 10'h3FF, 32'd3, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h3FF, 10'h3FF, 32'd4, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h000, 10'h000, 32'd5, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h3FF, 10'h000, 10'h0F0, 32'hFFFF_FFFF, 10'h3FF));
		send_item(FUNC_MANUAL_CLEAR, pack_item(10'h3FF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 10'h000));
		drain();

		// longest hold times across the wrap of the millisecond counter
		configure(TIMES_MAX, TIMES_MAX, TIMES_MAX, TIMES_MAX, 10'h3FF, 10'h3FF, '0);
		send_item(FUNC_EVALUATE, pack_item(10'h3FF, 10'h000, 10'h3FF, 32'hFFFF_FF00, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h3FF, 10'h000, 10'h3FF, 32'h0000_0EFE, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h3FF, 10'h000, 10'h3FF, 32'h0000_0EFF, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h3FF, 10'h3FF, 32'h0000_0EFF, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h3FF, 10'h3FF, 32'h0000_1EFD, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h3FF, 10'h3FF, 32'h0000_1EFE, 10'h000));
		send_item(FUNC_MANUAL_CLEAR, pack_item(10'h000, 10'h000, 10'h000, 32'h0000_1EFE, 10'h3FF));
		// pending dropped by a released trip
		send_item(FUNC_EVALUATE, pack_item(10'h3FF, 10'h000, 10'h3FF, 32'h0000_2000, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h000, 10'h3FF, 32'h0000_2001, 10'h000));
		drain();

		// injection on every fault overrides the condition bits
		configure('0, '0, '0, '0, '0, '0, 10'h3FF);
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h3FF, 10'h3FF, 32'd100, 10'h000));
		send_item(FUNC_EVALUATE, pack_item(10'h000, 10'h3FF, 10'h3FF, 32'd101, 10'h000));
		send_item(FUNC_MANUAL_CLEAR, pack_item(10'h000, 10'h000, 10'h000, 32'd101, 10'h3FF));

		// random rounds under several register settings
		trip_cond = '0;
		rec_cond  = '1;
		for (int p = 0; p < 6; p++) begin
			drain();
			tick_ms = $urandom();
			case (p)
			0: begin
				configure(rand_times(15), rand_times(15), rand_times(15), rand_times(15),
					rand_mask(), rand_mask(), '0);
				step_max = 6;
			end
			1: begin
				configure('0, '0, '0, '0, 10'h3FF, '0, rand_mask() & rand_mask());
				step_max = 3;
			end
			2: begin
				configure(TIMES_MAX, TIMES_MAX, TIMES_MAX, TIMES_MAX, '0, 10'h3FF, '0);
				step_max = 1500;
				tick_ms  = 32'hFFFF_F000;
			end
			3: begin
				configure(CONFIRM_LO_RST, CONFIRM_HI_RST, RECOVERY_LO_RST, RECOVERY_HI_RST,
					CRITICAL_RST, MANUAL_RST, INJECT_RST);
				step_max = 400;
			end
			4: begin
				configure(rand_word(), rand_word(), rand_word(), rand_word(),
					rand_mask(), rand_mask(), rand_mask() & rand_mask());
				step_max = 4095;
			end
			default: begin
				configure(rand_times(40), rand_times(40), rand_times(40), rand_times(40),
					10'h3FF, rand_mask(), rand_mask() & rand_mask() & rand_mask());
				step_max = 12;
				tick_ms  = 32'hFFFF_FFF0;
			end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stall the result side long enough to back up the input
				if (n == 40)
					hold_asks <= hold_asks + 1;
				roll = $urandom_range(0, 99);
				if (roll < 12) begin
					send_item(($urandom_range(0, 1) == 0) ? FUNC_EVALUATE : FUNC_MANUAL_CLEAR,
						pack_item(rand_mask(), rand_mask(), rand_mask(), $urandom(),
						rand_mask()));
				end else if (roll < 27) begin
					send_item(FUNC_MANUAL_CLEAR, pack_item(rand_mask(), rand_mask(), rand_mask(),
						tick_ms, ($urandom_range(0, 1) == 0) ? 10'h3FF : rand_mask()));
				end else begin
					// slowly changing conditions so that debounce and recovery complete
					trip_cond ^= rand_mask() & rand_mask() & rand_mask();
					rec_cond   = ~trip_cond ^ (rand_mask() & rand_mask() & rand_mask());
					sel        = (roll < 85) ? 10'h3FF : rand_mask();
					tick_ms   += FLM_NOW_W'($urandom_range(0, step_max));
					send_item(FUNC_EVALUATE, pack_item(trip_cond, rec_cond, sel, tick_ms,
						rand_mask()));
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Ran %0d evaluate rounds and %0d manual clears over nine register settings,",
			eval_beats, clear_beats);
		$display("with %0d fault confirmations and %0d fault releases predicted.",
			confirm_total, release_total);
		if (fail_count == 0)
			$display("[fault_lifecycle_manager] OK");
		else
			$display("[fault_lifecycle_manager] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/flm_pkg.sv
rtl/flm_cfg_regs.sv
rtl/flm_fault_lane.sv
rtl/fault_lifecycle_manager.sv
verif/fault_lifecycle_checker.sv
verif/fault_lifecycle_manager_tb.sv
